// ===== sv/irc_pkg.sv =====
package irc_pkg;

  localparam int MAX_DIM        = 512;
  localparam int TRIG_FRAC_BITS = 14;

  localparam int COORD_W = $clog2(MAX_DIM);
  localparam int DIM_W   = COORD_W + 1;
  localparam int ADDR_W  = 2 * COORD_W;
  localparam int PIX_W   = 8;
  localparam int TRIG_W  = 16;
  localparam int OFS_W   = COORD_W + 2;
  localparam int PROD_W  = TRIG_W + OFS_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int ROT_W   = SUM_W - TRIG_FRAC_BITS + 1;
  localparam int SRC_W   = ROT_W + 1;
  localparam int CFG_IDX_W = 8;

  localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIM);

  localparam int Q_DEPTH = 8;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = Q_PTR_W + 1;
  localparam int FRONT_STAGES = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEIGHT = 8'd0,
    CFG_WIDTH  = 8'd1,
    CFG_COS    = 8'd2,
    CFG_SIN    = 8'd3
  } irc_cfg_idx_t;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_FETCH = 1'b1
  } irc_kind_t;

  typedef struct packed {
    irc_kind_t         kind;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  pix;
    logic              ok;
  } irc_item_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic almost_full;
  } irc_q_stat_t;

endpackage

// ===== sv/image_rotate_center_nearest.sv =====
// A fetch goes through three front stages, one queue slot and a registered frame read.
// Throughput: one beat per cycle, load or fetch, set by the single frame memory port.
// busy rises only if the queue nears full; the receiver cannot stall, so it stays low.
// Reset (synchronous, rst_n low) restores the configuration registers and empties the pipeline and
// queue; the frame store is not cleared and needs no pass.
module image_rotate_center_nearest (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_kind,
  input  logic [irc_pkg::COORD_W-1:0]    in_row,
  input  logic [irc_pkg::COORD_W-1:0]    in_col,
  input  logic [irc_pkg::PIX_W-1:0]      in_pixel_in,
  output logic                           out_valid,
  output logic [irc_pkg::PIX_W-1:0]      out_pixel_out,
  output logic                           out_in_range,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [irc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [irc_pkg::TRIG_W-1:0]     cfg_data
);
  import irc_pkg::*;

  logic        acc, item_v, pop;
  irc_item_t   item, q_item;
  irc_q_stat_t qstat;

  assign cfg_ready = 1'b1;
  assign busy      = qstat.almost_full;
  assign acc       = start && !busy;

  irc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .in_kind     (in_kind),
    .in_row      (in_row),
    .in_col      (in_col),
    .in_pixel_in (in_pixel_in),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .item_v      (item_v),
    .item        (item)
  );

  irc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (item_v),
    .wdata (item),
    .pop   (pop),
    .rdata (q_item),
    .stat  (qstat)
  );

  irc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .qstat   (qstat),
    .item    (q_item),
    .pop     (pop),
    .res_v   (out_valid),
    .res_pix (out_pixel_out),
    .res_ok  (out_in_range)
  );

endmodule

// ===== sv/irc_front.sv =====
module irc_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           acc,
  input  logic                           in_kind,
  input  logic [irc_pkg::COORD_W-1:0]    in_row,
  input  logic [irc_pkg::COORD_W-1:0]    in_col,
  input  logic [irc_pkg::PIX_W-1:0]      in_pixel_in,
  input  logic                           cfg_we,
  input  logic [irc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [irc_pkg::TRIG_W-1:0]     cfg_data,
  output logic                           item_v,
  output irc_pkg::irc_item_t             item
);
  import irc_pkg::*;

  logic [DIM_W-1:0]         height_r, width_r;
  logic signed [TRIG_W-1:0] cos_r, sin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r <= MAX_DIM_V;
      width_r  <= MAX_DIM_V;
      cos_r    <= TRIG_W'(1 << TRIG_FRAC_BITS);
      sin_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEIGHT: height_r <= cfg_data[DIM_W-1:0];
        CFG_WIDTH:  width_r  <= cfg_data[DIM_W-1:0];
        CFG_COS:    cos_r    <= cfg_data;
        CFG_SIN:    sin_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0]   h_eff, w_eff;
  logic [COORD_W-1:0] cr, cc;

  assign h_eff = (height_r > MAX_DIM_V) ? MAX_DIM_V : height_r;
  assign w_eff = (width_r > MAX_DIM_V) ? MAX_DIM_V : width_r;
  assign cr    = h_eff[DIM_W-1:1];
  assign cc    = w_eff[DIM_W-1:1];

  // stage 1: offsets from the centre
  logic                    v1_r;
  irc_kind_t               kind1_r;
  logic [COORD_W-1:0]      row1_r, col1_r;
  logic [PIX_W-1:0]        pix1_r;
  logic signed [OFS_W-1:0] dr1_r, dc1_r;
  logic                    dok1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= acc;
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      kind1_r <= irc_kind_t'(in_kind);
      row1_r  <= in_row;
      col1_r  <= in_col;
      pix1_r  <= in_pixel_in;
      dr1_r   <= $signed({2'b00, in_row}) - $signed({2'b00, cr});
      dc1_r   <= $signed({2'b00, in_col}) - $signed({2'b00, cc});
      dok1_r  <= ({1'b0, in_row} < h_eff) && ({1'b0, in_col} < w_eff);
    end
  end

  // stage 2: products
  logic                     v2_r;
  irc_kind_t                kind2_r;
  logic [COORD_W-1:0]       row2_r, col2_r;
  logic [PIX_W-1:0]         pix2_r;
  logic                     dok2_r;
  logic signed [PROD_W-1:0] p_cr_r, p_sc_r, p_cc_r, p_sr_r;
  logic signed [PROD_W-1:0] c_ext, s_ext, dr_ext, dc_ext;

  assign c_ext  = PROD_W'(cos_r);
  assign s_ext  = PROD_W'(sin_r);
  assign dr_ext = PROD_W'(dr1_r);
  assign dc_ext = PROD_W'(dc1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      kind2_r <= kind1_r;
      row2_r  <= row1_r;
      col2_r  <= col1_r;
      pix2_r  <= pix1_r;
      dok2_r  <= dok1_r;
      p_cr_r  <= c_ext * dr_ext;
      p_sc_r  <= s_ext * dc_ext;
      p_cc_r  <= c_ext * dc_ext;
      p_sr_r  <= s_ext * dr_ext;
    end
  end

  // stage 3: truncate toward zero, recentre, range check
  function automatic logic signed [ROT_W-1:0] trunc_frac(input logic signed [SUM_W-1:0] s);
    logic [SUM_W-1:0] mag;
    logic [ROT_W-1:0] q;
    mag = s[SUM_W-1] ? (~s + 1'b1) : s;
    q   = ROT_W'(mag >> TRIG_FRAC_BITS);
    return s[SUM_W-1] ? $signed(~q + 1'b1) : $signed(q);
  endfunction

  logic signed [SUM_W-1:0] sum_r, sum_c;
  logic signed [SRC_W-1:0] sr, sc;
  logic                    src_ok;

  assign sum_r  = SUM_W'(p_cr_r) + SUM_W'(p_sc_r);
  assign sum_c  = SUM_W'(p_cc_r) - SUM_W'(p_sr_r);
  assign sr     = $signed(SRC_W'({1'b0, cr})) + SRC_W'(trunc_frac(sum_r));
  assign sc     = $signed(SRC_W'({1'b0, cc})) + SRC_W'(trunc_frac(sum_c));
  assign src_ok = !sr[SRC_W-1] && (sr[SRC_W-2:0] < (SRC_W-1)'(h_eff)) &&
                  !sc[SRC_W-1] && (sc[SRC_W-2:0] < (SRC_W-1)'(w_eff));

  logic      v3_r;
  irc_item_t item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    if (v2_r) begin
      item_r.kind <= kind2_r;
      item_r.pix  <= pix2_r;
      item_r.ok   <= dok2_r && src_ok;
      if (kind2_r == KIND_LOAD) item_r.addr <= {row2_r, col2_r};
      else                      item_r.addr <= {sr[COORD_W-1:0], sc[COORD_W-1:0]};
    end
  end

  assign item_v = v3_r;
  assign item   = item_r;

  a_acc_reaches_queue: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> ##3 item_v)
    else $error("accepted beat did not reach the queue");

endmodule

// ===== sv/irc_queue.sv =====
module irc_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  irc_pkg::irc_item_t   wdata,
  input  logic                 pop,
  output irc_pkg::irc_item_t   rdata,
  output irc_pkg::irc_q_stat_t stat
);
  import irc_pkg::*;

  irc_item_t          slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wptr_r, rptr_r;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign do_push = push && !stat.full;
  assign do_pop  = pop && !stat.empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop)      cnt_nxt = cnt_r + 1'b1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) wptr_r <= wptr_r + 1'b1;
      if (do_pop)  rptr_r <= rptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wptr_r] <= wdata;
  end

  assign rdata            = slot_r[rptr_r];
  assign stat.empty       = (cnt_r == '0);
  assign stat.full        = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign stat.almost_full = (cnt_r >= Q_CNT_W'(Q_DEPTH - FRONT_STAGES - 1));

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    stat.full |-> !push)
    else $error("push into full queue");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count lost a beat");

endmodule

// ===== sv/irc_back.sv =====
module irc_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  irc_pkg::irc_q_stat_t      qstat,
  input  irc_pkg::irc_item_t        item,
  output logic                      pop,
  output logic                      res_v,
  output logic [irc_pkg::PIX_W-1:0] res_pix,
  output logic                      res_ok
);
  import irc_pkg::*;

  logic [PIX_W-1:0] frame_mem [1 << ADDR_W];
  logic [PIX_W-1:0] rd_r;
  logic             v_r, ok_r;

  assign pop = !qstat.empty;

  always_ff @(posedge clk) begin
    if (pop && item.kind == KIND_LOAD) frame_mem[item.addr] <= item.pix;
    if (pop && item.kind == KIND_FETCH && item.ok) rd_r <= frame_mem[item.addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= pop && (item.kind == KIND_FETCH);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) ok_r <= item.ok;
  end

  assign res_v   = v_r;
  assign res_ok  = ok_r;
  assign res_pix = ok_r ? rd_r : '0;

  a_result_from_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    res_v |-> $past(pop && item.kind == KIND_FETCH))
    else $error("result strobe without fetch beat");

endmodule
